@@ sv/fbgm_pkg.sv @@
// ----------------------------------------------------------------------------
// fbgm_pkg
// Shared widths, constants and request structs for the frame brightness
// glyph match core.
// ----------------------------------------------------------------------------
package fbgm_pkg;

  localparam int VOCAB_ENTRIES    = 128;
  localparam int MAX_FRAME_PIXELS = 4096;
  localparam int GRAY_LEVELS      = 256;

  localparam int PIX_W    = $clog2(GRAY_LEVELS);
  localparam int VOCAB_AW = $clog2(VOCAB_ENTRIES);
  localparam int VOCAB_CW = $clog2(VOCAB_ENTRIES + 1);
  localparam int COUNT_W  = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int SUM_W    = 20;
  localparam int DIST_W   = PIX_W + 1;
  localparam int STEP_W   = $clog2(PIX_W);

  typedef struct packed {
    logic               go;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                go;
    logic [PIX_W-1:0]    target;
    logic [VOCAB_CW-1:0] limit;
  } srch_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] symbol;
  } srch_rsp_t;

  typedef struct packed {
    logic                en;
    logic [VOCAB_AW-1:0] addr;
    logic [PIX_W-1:0]    symbol;
    logic [PIX_W-1:0]    level;
  } tbl_wr_t;

endpackage

@@ sv/fbgm_divider.sv @@
// ----------------------------------------------------------------------------
// fbgm_divider
// Restoring divider, one quotient bit per cycle, for the frame average.
// ----------------------------------------------------------------------------
module fbgm_divider (
  input  logic               clk,
  input  logic               rst,
  input  fbgm_pkg::div_req_t req,
  output fbgm_pkg::div_rsp_t rsp
);

  // quotient is known to stay below the gray range, so only PIX_W steps run
  logic                         active;
  logic [fbgm_pkg::STEP_W-1:0]  step;
  logic [fbgm_pkg::SUM_W-1:0]   rem;
  logic [fbgm_pkg::SUM_W-1:0]   dsh;
  logic [fbgm_pkg::PIX_W-1:0]   quot;
  logic                         fits;
  logic [fbgm_pkg::PIX_W-1:0]   quot_next;
  logic                         done_q;
  logic [fbgm_pkg::PIX_W-1:0]   quot_q;

  assign fits      = rem >= dsh;
  assign quot_next = {quot[fbgm_pkg::PIX_W-2:0], fits};
  assign rsp       = {done_q, quot_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
        step   <= fbgm_pkg::STEP_W'(fbgm_pkg::PIX_W - 1);
      end else if (active) begin
        step <= step - 1'b1;
        if (step == '0) begin
          active <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem  <= req.dividend;
      dsh  <= fbgm_pkg::SUM_W'(req.divisor) << (fbgm_pkg::PIX_W - 1);
      quot <= '0;
    end else if (active) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= quot_next;
      if (step == '0) begin
        quot_q <= quot_next;
      end
    end
  end

endmodule

@@ sv/fbgm_search.sv @@
// ----------------------------------------------------------------------------
// fbgm_search
// Vocabulary table memory and a sequential nearest-brightness search.
// ----------------------------------------------------------------------------
module fbgm_search (
  input  logic                clk,
  input  logic                rst,
  input  fbgm_pkg::srch_req_t req,
  input  fbgm_pkg::tbl_wr_t   wr,
  output fbgm_pkg::srch_rsp_t rsp
);

  logic [2*fbgm_pkg::PIX_W-1:0] mem [fbgm_pkg::VOCAB_ENTRIES];
  logic [2*fbgm_pkg::PIX_W-1:0] rd_data;

  logic                          active;
  logic [fbgm_pkg::VOCAB_CW-1:0] issue;
  logic [fbgm_pkg::VOCAB_CW-1:0] issue_inc;
  logic [fbgm_pkg::VOCAB_CW-1:0] limit;
  logic [fbgm_pkg::PIX_W-1:0]    target;
  logic                          rd_valid;
  logic                          rd_last;
  logic [fbgm_pkg::DIST_W-1:0]   best_dist;
  logic [fbgm_pkg::PIX_W-1:0]    best_sym;
  logic                          done_q;
  logic [fbgm_pkg::PIX_W-1:0]    sym_q;

  logic [fbgm_pkg::PIX_W-1:0]    rd_sym;
  logic [fbgm_pkg::PIX_W-1:0]    rd_level;
  logic [fbgm_pkg::PIX_W-1:0]    gap;
  logic                          better;
  logic [fbgm_pkg::PIX_W-1:0]    best_sym_next;

  assign issue_inc = issue + 1'b1;
  assign rd_sym    = rd_data[2*fbgm_pkg::PIX_W-1:fbgm_pkg::PIX_W];
  assign rd_level  = rd_data[fbgm_pkg::PIX_W-1:0];
  assign rsp       = {done_q, sym_q};

  always_comb begin
    gap           = (target >= rd_level) ? (target - rd_level) : (rd_level - target);
    better        = fbgm_pkg::DIST_W'(gap) < best_dist;
    best_sym_next = (rd_valid && better) ? rd_sym : best_sym;
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.symbol, wr.level};
    end
    if (active) begin
      rd_data <= mem[issue[fbgm_pkg::VOCAB_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rd_valid <= active && !req.go;
      done_q   <= rd_valid && rd_last;
      if (req.go) begin
        active <= 1'b1;
        issue  <= '0;
      end else if (active) begin
        issue   <= issue_inc;
        rd_last <= issue_inc == limit;
        if (issue_inc == limit) begin
          active <= 1'b0;
        end
      end
    end
  end

  // only a strictly closer entry replaces the best, so ties keep the lower index
  always_ff @(posedge clk) begin
    if (req.go) begin
      limit     <= req.limit;
      target    <= req.target;
      best_dist <= fbgm_pkg::DIST_W'(fbgm_pkg::GRAY_LEVELS);
    end else if (rd_valid && better) begin
      best_dist <= fbgm_pkg::DIST_W'(gap);
    end
    best_sym <= best_sym_next;
    if (rd_valid && rd_last) begin
      sym_q <= best_sym_next;
    end
  end

endmodule

@@ sv/frame_brightness_glyph_match_core.sv @@
// ----------------------------------------------------------------------------
// frame_brightness_glyph_match_core
// Accumulates frame pixels, divides for the average and finds the glyph
// whose brightness is nearest to it.
// ----------------------------------------------------------------------------
//  channel  | ports                                            | handshake
//  request  | mode pixel last_pixel entry_index entry_symbol   | start & !busy
//           | entry_brightness                                 |
//  result   | symbol frame_average                             | done, one cycle
//  config   | wr_data (vocab_count)                            | wr_en
//
// a table write or a pixel that does not end the frame leaves busy low
// a last pixel keeps busy high through the bit-serial divider, the search start,
// one table read per searched entry (limit, being vocab_count held to 1..128)
// and the registering and hand-back of the result
// reset clears the sums, the sequencer and vocab_count to 1; the table is not
// cleared; the receiver cannot stall, so a result is never held back
// ----------------------------------------------------------------------------
module frame_brightness_glyph_match_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [7:0]                    pixel,
  input  logic                          last_pixel,
  input  logic [6:0]                    entry_index,
  input  logic [7:0]                    entry_symbol,
  input  logic [7:0]                    entry_brightness,
  input  logic                          wr_en,
  input  logic [7:0]                    wr_data,
  output logic                          done,
  output logic [7:0]                    symbol,
  output logic [7:0]                    frame_average
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIV    = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [7:0]                    vocab_count;
  logic [fbgm_pkg::SUM_W-1:0]    pixel_sum;
  logic [fbgm_pkg::COUNT_W-1:0]  pixel_count;
  logic [fbgm_pkg::SUM_W-1:0]    pixel_sum_next;
  logic [fbgm_pkg::COUNT_W-1:0]  pixel_count_next;
  logic                          accept;
  logic [fbgm_pkg::VOCAB_CW-1:0] limit;

  fbgm_pkg::div_req_t  div_req;
  fbgm_pkg::div_rsp_t  div_rsp;
  fbgm_pkg::srch_req_t srch_req;
  fbgm_pkg::srch_rsp_t srch_rsp;
  fbgm_pkg::tbl_wr_t   tbl_wr;

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  always_comb begin
    pixel_sum_next   = pixel_sum;
    pixel_count_next = pixel_count;
    if (32'(pixel_count) < fbgm_pkg::MAX_FRAME_PIXELS) begin
      pixel_sum_next   = pixel_sum + fbgm_pkg::SUM_W'(pixel);
      pixel_count_next = pixel_count + 1'b1;
    end
  end

  always_comb begin
    if (vocab_count == '0) begin
      limit = fbgm_pkg::VOCAB_CW'(1);
    end else if (32'(vocab_count) > fbgm_pkg::VOCAB_ENTRIES) begin
      limit = fbgm_pkg::VOCAB_CW'(fbgm_pkg::VOCAB_ENTRIES);
    end else begin
      limit = fbgm_pkg::VOCAB_CW'(vocab_count);
    end
  end

  always_comb begin
    div_req.go       = accept && !mode && last_pixel;
    div_req.dividend = pixel_sum_next;
    div_req.divisor  = pixel_count_next;

    srch_req.go     = (state == ST_DIV) && div_rsp.done;
    srch_req.target = div_rsp.quotient;
    srch_req.limit  = limit;

    tbl_wr.en     = accept && mode && (32'(entry_index) < fbgm_pkg::VOCAB_ENTRIES);
    tbl_wr.addr   = fbgm_pkg::VOCAB_AW'(entry_index);
    tbl_wr.symbol = entry_symbol;
    tbl_wr.level  = entry_brightness;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_req.go) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      vocab_count <= 8'd1;
      pixel_sum   <= '0;
      pixel_count <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        vocab_count <= wr_data;
      end
      if (accept && !mode) begin
        // the frame restarts once its last pixel has gone to the divider
        if (last_pixel) begin
          pixel_sum   <= '0;
          pixel_count <= '0;
        end else begin
          pixel_sum   <= pixel_sum_next;
          pixel_count <= pixel_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (srch_req.go) begin
      frame_average <= div_rsp.quotient;
    end
  end

  fbgm_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fbgm_search u_search (
    .clk (clk),
    .rst (rst),
    .req (srch_req),
    .wr  (tbl_wr),
    .rsp (srch_rsp)
  );

  assign done   = srch_rsp.done;
  assign symbol = srch_rsp.symbol;

  // a result only comes out of a running search
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // the block frees itself right after delivering the result
  a_done_release: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy held after result");

  // only a last frame pixel starts the divide and search
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !mode && last_pixel))
    else $error("busy raised without a last pixel request");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for frame_brightness_glyph_match_core. Loads glyph
// table entries, streams pixel frames of short, medium and long length
// under random sender gaps, changes the search count between frames and
// checks every glyph result against an internal average and nearest-level
// search.
// ----------------------------------------------------------------------------

localparam bit MODE_PIXEL = 1'b0;
localparam bit MODE_TABLE = 1'b1;

typedef struct packed {
  bit       mode;
  bit [7:0] pixel;
  bit       last;
  bit [6:0] slot;
  bit [7:0] glyph;
  bit [7:0] level;
} stream_item_t;

typedef struct packed {
  bit [7:0] glyph;
  bit [7:0] average;
} glyph_result_t;

class glyph_match_scoreboard;
  bit [19:0]     frame_sum;
  bit [12:0]     frame_pixels;
  bit [7:0]      glyph_code [fbgm_pkg::VOCAB_ENTRIES];
  bit [7:0]      glyph_level [fbgm_pkg::VOCAB_ENTRIES];
  bit [7:0]      search_count;
  glyph_result_t pending_glyphs [$];
  int            mismatches;

  function new();
    frame_sum    = '0;
    frame_pixels = '0;
    search_count = 8'd1;
    mismatches   = 0;
    foreach (glyph_code[i]) begin
      glyph_code[i]  = '0;
      glyph_level[i] = '0;
    end
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // zero and oversize counts are clamped; only a strictly closer level wins
  function bit [7:0] nearest_glyph(bit [7:0] target);
    int       n;
    int       best_dist;
    int       gap;
    bit [7:0] best;
    n = (search_count == 0) ? 1 : int'(search_count);
    if (n > fbgm_pkg::VOCAB_ENTRIES) n = fbgm_pkg::VOCAB_ENTRIES;
    best_dist = fbgm_pkg::GRAY_LEVELS;
    best      = glyph_code[0];
    for (int i = 0; i < n; i++) begin
      gap = int'(target) - int'(glyph_level[i]);
      if (gap < 0) gap = -gap;
      if (gap < best_dist) begin
        best_dist = gap;
        best      = glyph_code[i];
      end
    end
    return best;
  endfunction

  function void note_request(stream_item_t it);
    glyph_result_t res;
    if (it.mode == MODE_TABLE) begin
      // a 7-bit slot always lies inside the table
      glyph_code[it.slot]  = it.glyph;
      glyph_level[it.slot] = it.level;
      return;
    end
    // count saturates, later pixels of an over-long frame are dropped
    if (frame_pixels < fbgm_pkg::MAX_FRAME_PIXELS) begin
      frame_sum    += 20'(it.pixel);
      frame_pixels += 13'd1;
    end
    if (!it.last) return;
    res.average = (frame_pixels != 0) ? 8'(frame_sum / frame_pixels) : 8'd0;
    res.glyph   = nearest_glyph(res.average);
    pending_glyphs.insert(pending_glyphs.size(), res);
    frame_sum    = '0;
    frame_pixels = '0;
  endfunction

  function void check_result(logic [7:0] glyph, logic [7:0] average);
    glyph_result_t want;
    if (pending_glyphs.size() == 0) begin
      flag($sformatf("unexpected result symbol=%02h average=%02h", glyph, average));
      return;
    end
    want = pending_glyphs.pop_front();
    if (glyph !== want.glyph || average !== want.average)
      flag($sformatf("symbol exp %02h got %02h, average exp %02h got %02h",
                     want.glyph, glyph, want.average, average));
  endfunction
endclass

module tb_top;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       mode;
  logic [7:0] pixel;
  logic       last_pixel;
  logic [6:0] entry_index;
  logic [7:0] entry_symbol;
  logic [7:0] entry_brightness;
  logic       wr_en;
  logic [7:0] wr_data;
  logic       done;
  logic [7:0] symbol;
  logic [7:0] frame_average;

  glyph_match_scoreboard sb;
  int                    sender_idle;
  bit                    table_loaded [fbgm_pkg::VOCAB_ENTRIES];

  frame_brightness_glyph_match_core uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .pixel            (pixel),
    .last_pixel       (last_pixel),
    .entry_index      (entry_index),
    .entry_symbol     (entry_symbol),
    .entry_brightness (entry_brightness),
    .wr_en            (wr_en),
    .wr_data          (wr_data),
    .done             (done),
    .symbol           (symbol),
    .frame_average    (frame_average)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(symbol, frame_average);
  end

  function automatic stream_item_t make_item(bit m, bit [7:0] px, bit lst,
                                             bit [6:0] sl, bit [7:0] gl, bit [7:0] lv);
    stream_item_t it;
    it.mode  = m;
    it.pixel = px;
    it.last  = lst;
    it.slot  = sl;
    it.glyph = gl;
    it.level = lv;
    return it;
  endfunction

  // multiples of 32 up to 224 and the top level 255: levels and pixel anchors
  // from this set give exact and midpoint ties in the search
  function automatic bit [7:0] pick_level();
    int v;
    v = $urandom_range(0, 8) * 32;
    return (v > 255) ? 8'hFF : 8'(v);
  endfunction

  function automatic stream_item_t table_write(bit [6:0] sl);
    stream_item_t it;
    it       = make_item(MODE_TABLE, 8'($urandom), 1'($urandom), sl, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 1)) it.level = pick_level();
    return it;
  endfunction

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 8);
      6, 7, 8:          return $urandom_range(9, 40);
      default:          return $urandom_range(41, 300);
    endcase
  endfunction

  function automatic bit [7:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd128;
      4:       return 8'($urandom_range(129, 254));
      5:       return 8'd255;
      default: return 8'($urandom_range(3, 127));
    endcase
  endfunction

  task automatic issue_request(input stream_item_t it);
    while ($urandom_range(0, 99) < sender_idle) begin
      start = 1'b0;
      @(negedge clk);
    end
    start            = 1'b1;
    mode             = it.mode;
    pixel            = it.pixel;
    last_pixel       = it.last;
    entry_index      = it.slot;
    entry_symbol     = it.glyph;
    entry_brightness = it.level;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(it);
    if (it.mode == MODE_TABLE) table_loaded[it.slot] = 1'b1;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending_glyphs.size() != 0) @(negedge clk);
  endtask

  // write only while idle, then load any entry the new count would search
  task automatic load_vocab_count(input bit [7:0] value);
    int n;
    wait_results();
    repeat (160) @(negedge clk);
    wr_en   = 1'b1;
    wr_data = value;
    @(negedge clk);
    wr_en = 1'b0;
    sb.search_count = value;
    n = (value == 0) ? 1 : int'(value);
    if (n > fbgm_pkg::VOCAB_ENTRIES) n = fbgm_pkg::VOCAB_ENTRIES;
    for (int i = 0; i < n; i++)
      if (!table_loaded[i]) issue_request(table_write(7'(i)));
  endtask

  // style: 0 random, 1 flat anchor, 2 black/white, 3 anchor with jitter, 4 all white
  task automatic random_frame(input int len, input int style, output int items);
    stream_item_t it;
    bit [7:0]     anchor;
    anchor = pick_level();
    items  = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        issue_request(table_write(7'($urandom)));
        items++;
      end
      it      = make_item(MODE_PIXEL, 8'($urandom), i == len - 1, 7'($urandom),
                          8'($urandom), 8'($urandom));
      case (style)
        1:       it.pixel = anchor;
        2:       it.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        3:       it.pixel = anchor + 8'($urandom_range(0, 6)) - 8'd3;
        4:       it.pixel = 8'hFF;
        default: ;
      endcase
      issue_request(it);
      items++;
    end
  endtask

  task automatic run_phase(input int idle, input int budget);
    int sent;
    int n;
    sender_idle = idle;
    sent        = 0;
    load_vocab_count(pick_count());
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) load_vocab_count(pick_count());
      random_frame(pick_length(), $urandom_range(0, 3), n);
      sent += n;
    end
  endtask

  initial begin
    int n;
    sb               = new();
    rst              = 1'b1;
    start            = 1'b0;
    mode             = MODE_PIXEL;
    pixel            = '0;
    last_pixel       = 1'b0;
    entry_index      = '0;
    entry_symbol     = '0;
    entry_brightness = '0;
    wr_en            = 1'b0;
    wr_data          = '0;
    sender_idle      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // table writes, one carrying a stray last flag
    issue_request(make_item(MODE_TABLE, 8'hFF, 1'b1, 7'd0, 8'hA5, 8'h00));
    issue_request(make_item(MODE_TABLE, 8'h00, 1'b0, 7'd127, 8'hFF, 8'hFF));
    issue_request(make_item(MODE_TABLE, 8'h00, 1'b0, 7'd1, 8'h5A, 8'h80));
    issue_request(make_item(MODE_TABLE, 8'h00, 1'b0, 7'd2, 8'h00, 8'h80));
    // one-pixel frames at both ends of the gray range, reset count of one
    issue_request(make_item(MODE_PIXEL, 8'h00, 1'b1, 7'd0, 8'h00, 8'h00));
    issue_request(make_item(MODE_PIXEL, 8'hFF, 1'b1, 7'h7F, 8'hFF, 8'hFF));
    load_vocab_count(8'd3);
    issue_request(make_item(MODE_PIXEL, 8'hFF, 1'b0, 7'd0, 8'h00, 8'h00));
    issue_request(make_item(MODE_PIXEL, 8'hFE, 1'b1, 7'd0, 8'h00, 8'h00));
    // average rounds down
    issue_request(make_item(MODE_PIXEL, 8'h01, 1'b0, 7'd0, 8'h00, 8'h00));
    issue_request(make_item(MODE_PIXEL, 8'h02, 1'b1, 7'd0, 8'h00, 8'h00));
    // exact tie between entries 1 and 2, midpoint tie between 0 and 1
    issue_request(make_item(MODE_PIXEL, 8'h80, 1'b1, 7'd0, 8'h00, 8'h00));
    issue_request(make_item(MODE_PIXEL, 8'h40, 1'b1, 7'd0, 8'h00, 8'h00));
    // table write in the middle of a frame
    issue_request(make_item(MODE_PIXEL, 8'h64, 1'b0, 7'd0, 8'h00, 8'h00));
    issue_request(make_item(MODE_TABLE, 8'h00, 1'b1, 7'd3, 8'h33, 8'h40));
    issue_request(make_item(MODE_PIXEL, 8'h65, 1'b1, 7'd0, 8'h00, 8'h00));
    // zero count searches entry 0 only
    load_vocab_count(8'd0);
    issue_request(make_item(MODE_PIXEL, 8'h80, 1'b1, 7'd0, 8'h00, 8'h00));

    run_phase(24, 260);
    // long all-white frame
    random_frame(150, 4, n);
    run_phase(82, 260);
    run_phase(0, 260);

    wait_results();
    repeat (200) @(negedge clk);
    if (sb.pending_glyphs.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending_glyphs.size()));
    if (sb.mismatches == 0) begin
      $display("** frame_brightness_glyph_match_core: PASSED **");
    end else begin
      $display("** frame_brightness_glyph_match_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[%0t] timeout", $time);
    $display("** frame_brightness_glyph_match_core: FAILED **");
    $finish;
  end

endmodule

@@ frame_brightness_glyph_match_core.f @@
sv/fbgm_pkg.sv
sv/fbgm_divider.sv
sv/fbgm_search.sv
sv/frame_brightness_glyph_match_core.sv
sim/tb_top.sv
